// ===== rtl/core/tccr_pkg.sv =====
// shared types and codes for the two-click circle rasterizer
// no dependencies; imported by tccr_isqrt and two_click_circle_rasterizer
`default_nettype none

package tccr_pkg;

    // item kind carried on the input tuser bit
    typedef enum logic
    {
        CMD_CLICK = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_t;

    // status of the serial square root unit
    typedef struct packed
    {
        logic busy;
        logic done;
    } sq_stat_t;

    // fixed widths of the stream payload
    localparam int unsigned IN_FIELD_BITS = 11;
    localparam int unsigned PIX_BITS      = 14;
    localparam int unsigned S_DATA_BITS   = 24;
    localparam int unsigned M_DATA_BITS   = 32;

endpackage

`default_nettype wire

// ===== rtl/core/tccr_isqrt.sv =====
// restoring integer square root, one root bit per cycle
// depends on tccr_pkg for the status struct
`default_nettype none

module tccr_isqrt #(
    parameter int unsigned ROOT_BITS = 12
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [2*ROOT_BITS-1:0]   radicand,
    output tccr_pkg::sq_stat_t            stat,
    output logic      [ROOT_BITS-1:0]     root
);
    import tccr_pkg::*;

    localparam int unsigned RAD_BITS = 2 * ROOT_BITS;
    localparam int unsigned CNT_BITS = $clog2(ROOT_BITS);

    logic [RAD_BITS-1:0]    rad_reg, rad_next;
    logic [ROOT_BITS:0]     rem_reg, rem_next;
    logic [ROOT_BITS-1:0]   root_reg, root_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [ROOT_BITS+2:0]   shifted;
    logic [ROOT_BITS+2:0]   trial;
    logic [ROOT_BITS+2:0]   diff;
    logic                   fits;

    // bring down the next two radicand bits and try the next root bit
    assign shifted = {rem_reg, rad_reg[RAD_BITS-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign diff    = shifted - trial;
    assign fits    = (shifted >= trial);

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_BITS-3:0], 2'b00};
            rem_next  = fits ? diff[ROOT_BITS:0] : shifted[ROOT_BITS:0];
            root_next = {root_reg[ROOT_BITS-2:0], fits};
            if (cnt_reg == CNT_BITS'(ROOT_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

`default_nettype wire

// ===== rtl/core/two_click_circle_rasterizer.sv =====
// top level of the two-click circle rasterizer: sequencer, serial squarer, output register
// depends on tccr_pkg and tccr_isqrt
`default_nettype none

// a tick inside a column gives its pixel in the cycle after the transaction
// one tick per cycle within a column while the output register has room; the tick that ends a column
//   is followed by a busy spell: a setup state, the square root steps for the next row, then a return to idle
// a second click runs in turn two serial squares, a root, a square and a root
// the shift-add squarer and the square root unit each retire one bit per cycle
// reset: asynchronous, active low; clears centre, armed/drawing flags and the output valid

module two_click_circle_rasterizer #(
    parameter int unsigned COORD_BITS = 11
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [tccr_pkg::S_DATA_BITS-1:0]    s_tdata,  // click_x, click_y, zero pad
    input  wire logic                                s_tuser,  // command
    // output stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [tccr_pkg::M_DATA_BITS-1:0]    m_tdata,  // pixel_x, pixel_y, busy_res, pad
    output logic                                     m_tuser,  // pixel_valid
    output logic                                     m_tlast   // last_pixel
);
    import tccr_pkg::*;

    // radius, column and row fit in one bit more than a coordinate
    localparam int unsigned RW  = COORD_BITS + 1;
    // squares and square root radicands
    localparam int unsigned SW  = 2 * RW;
    // width that holds a click field before masking to COORD_BITS
    localparam int unsigned IW  = (COORD_BITS > IN_FIELD_BITS) ? COORD_BITS : IN_FIELD_BITS;
    // signed width that holds centre plus or minus the offset without overflow
    localparam int unsigned PW  = (COORD_BITS + 3 > PIX_BITS) ? COORD_BITS + 3 : PIX_BITS;
    localparam int unsigned CTW = $clog2(RW);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SQ_DX,
        S_SQ_DY,
        S_ROOT_R,
        S_SQ_R,
        S_PREP,
        S_ROOT_Y
    } state_t;

    state_t                 state_reg, state_next;
    logic                   armed_reg, armed_next;
    logic                   drawing_reg, drawing_next;
    logic [COORD_BITS-1:0]  centre_x_reg, centre_x_next;
    logic [COORD_BITS-1:0]  centre_y_reg, centre_y_next;
    logic [COORD_BITS-1:0]  dy_reg, dy_next;
    logic [RW-1:0]          column_reg, column_next;
    logic [RW-1:0]          row_reg, row_next;
    logic [2:0]             octant_reg, octant_next;
    logic [SW-1:0]          x2_reg, x2_next;     // column squared
    logic [SW-1:0]          x2n_reg, x2n_next;   // next column squared
    logic [SW-1:0]          r2_reg, r2_next;     // radius squared
    logic                   ok_reg, ok_next;     // next column is inside the octant

    // serial squarer
    logic [SW-1:0]          mcd_reg, mcd_next;
    logic [RW-1:0]          mlr_reg, mlr_next;
    logic [SW-1:0]          acc_reg, acc_next;
    logic [CTW-1:0]         cnt_reg, cnt_next;
    logic [SW-1:0]          acc_step;
    logic                   cnt_last;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic                   out_pvalid_reg, out_pvalid_next;
    logic [PIX_BITS-1:0]    out_px_reg, out_px_next;
    logic [PIX_BITS-1:0]    out_py_reg, out_py_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_busy_reg, out_busy_next;

    // square root unit
    logic                   sq_start;
    logic [SW-1:0]          sq_rad;
    sq_stat_t               sq_stat;
    logic [RW-1:0]          sq_root;

    // input decode
    logic                   s_xfer;
    logic [IW-1:0]          click_x_w, click_y_w;
    logic [COORD_BITS-1:0]  cx, cy;
    logic [COORD_BITS-1:0]  dx_abs, dy_abs;

    // pixel arithmetic
    logic                   swap, neg_x, neg_y;
    logic [RW-1:0]          sel_x, sel_y;
    logic [PW-1:0]          off_x, off_y;
    logic [PW-1:0]          sum_x, sum_y;

    tccr_isqrt #(
        .ROOT_BITS (RW)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .stat     (sq_stat),
        .root     (sq_root)
    );

    // take new transactions only between computations and with room in the output register
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign s_xfer   = s_tvalid && s_tready;

    // only the low COORD_BITS bits of a click are used
    assign click_x_w = IW'(s_tdata[IN_FIELD_BITS-1:0]);
    assign click_y_w = IW'(s_tdata[2*IN_FIELD_BITS-1:IN_FIELD_BITS]);
    assign cx        = click_x_w[COORD_BITS-1:0];
    assign cy        = click_y_w[COORD_BITS-1:0];

    // distance from the centre; only magnitudes matter once squared
    assign dx_abs = (centre_x_reg >= cx) ? (centre_x_reg - cx) : (cx - centre_x_reg);
    assign dy_abs = (centre_y_reg >= cy) ? (centre_y_reg - cy) : (cy - centre_y_reg);

    // one shift-add step of the squarer
    assign acc_step = acc_reg + (mlr_reg[0] ? mcd_reg : '0);
    assign cnt_last = (cnt_reg == CTW'(RW - 1));

    // octant order (x,y) (y,x) (-x,y) (-y,x) (-x,-y) (-y,-x) (x,-y) (y,-x)
    assign swap  = octant_reg[0];
    assign neg_x = octant_reg[1] ^ octant_reg[2];
    assign neg_y = octant_reg[2];
    assign sel_x = swap ? row_reg : column_reg;
    assign sel_y = swap ? column_reg : row_reg;
    assign off_x = neg_x ? (PW'(0) - PW'(sel_x)) : PW'(sel_x);
    assign off_y = neg_y ? (PW'(0) - PW'(sel_y)) : PW'(sel_y);
    assign sum_x = PW'(centre_x_reg) + off_x;
    assign sum_y = PW'(centre_y_reg) + off_y;

    always_comb
    begin
        state_next      = state_reg;
        armed_next      = armed_reg;
        drawing_next    = drawing_reg;
        centre_x_next   = centre_x_reg;
        centre_y_next   = centre_y_reg;
        dy_next         = dy_reg;
        column_next     = column_reg;
        row_next        = row_reg;
        octant_next     = octant_reg;
        x2_next         = x2_reg;
        x2n_next        = x2n_reg;
        r2_next         = r2_reg;
        ok_next         = ok_reg;
        mcd_next        = mcd_reg;
        mlr_next        = mlr_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        out_pvalid_next = out_pvalid_reg;
        out_px_next     = out_px_reg;
        out_py_next     = out_py_reg;
        out_last_next   = out_last_reg;
        out_busy_next   = out_busy_reg;
        sq_start        = 1'b0;
        sq_rad          = '0;

        // result taken downstream
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_xfer)
                begin
                    if (s_tuser == CMD_CLICK)
                    begin
                        // clicks during a circle are dropped
                        if (!drawing_reg)
                        begin
                            if (!armed_reg)
                            begin
                                centre_x_next = cx;
                                centre_y_next = cy;
                                armed_next    = 1'b1;
                            end
                            else
                            begin
                                armed_next   = 1'b0;
                                drawing_next = 1'b1;
                                dy_next      = dy_abs;
                                mcd_next     = SW'(dx_abs);
                                mlr_next     = RW'(dx_abs);
                                acc_next     = '0;
                                cnt_next     = '0;
                                octant_next  = '0;
                                state_next   = S_SQ_DX;
                            end
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        if (!drawing_reg)
                        begin
                            // tick with no circle gives an all-zero result
                            out_pvalid_next = 1'b0;
                            out_px_next     = '0;
                            out_py_next     = '0;
                            out_last_next   = 1'b0;
                            out_busy_next   = 1'b0;
                        end
                        else
                        begin
                            out_pvalid_next = 1'b1;
                            out_px_next     = sum_x[PIX_BITS-1:0];
                            out_py_next     = sum_y[PIX_BITS-1:0];
                            out_last_next   = 1'b0;
                            out_busy_next   = 1'b1;
                            if (octant_reg == 3'd7)
                            begin
                                octant_next = '0;
                                if (ok_reg)
                                begin
                                    // move on to the next column and find its row
                                    column_next = column_reg + 1'b1;
                                    x2_next     = x2n_reg;
                                    state_next  = S_PREP;
                                end
                                else
                                begin
                                    out_last_next = 1'b1;
                                    out_busy_next = 1'b0;
                                    drawing_next  = 1'b0;
                                end
                            end
                            else
                            begin
                                octant_next = octant_reg + 1'b1;
                            end
                        end
                    end
                end
            end

            S_SQ_DX:
            begin
                acc_next = acc_step;
                mcd_next = {mcd_reg[SW-2:0], 1'b0};
                mlr_next = {1'b0, mlr_reg[RW-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    mcd_next   = SW'(dy_reg);
                    mlr_next   = RW'(dy_reg);
                    cnt_next   = '0;
                    state_next = S_SQ_DY;
                end
            end

            S_SQ_DY:
            begin
                acc_next = acc_step;
                mcd_next = {mcd_reg[SW-2:0], 1'b0};
                mlr_next = {1'b0, mlr_reg[RW-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    // radius is the root of dx^2 + dy^2
                    sq_start   = 1'b1;
                    sq_rad     = acc_step;
                    state_next = S_ROOT_R;
                end
            end

            S_ROOT_R:
            begin
                if (sq_stat.done)
                begin
                    mcd_next   = SW'(sq_root);
                    mlr_next   = sq_root;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = S_SQ_R;
                end
            end

            S_SQ_R:
            begin
                acc_next = acc_step;
                mcd_next = {mcd_reg[SW-2:0], 1'b0};
                mlr_next = {1'b0, mlr_reg[RW-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    r2_next     = acc_step;
                    column_next = '0;
                    x2_next     = '0;
                    state_next  = S_PREP;
                end
            end

            S_PREP:
            begin
                // row = isqrt(R^2 - x^2); column stays within the octant so no underflow
                sq_start   = 1'b1;
                sq_rad     = r2_reg - x2_reg;
                x2n_next   = x2_reg + SW'({column_reg, 1'b1});
                state_next = S_ROOT_Y;
            end

            S_ROOT_Y:
            begin
                // 2*(x+1)^2 <= R^2 decides whether another column follows
                ok_next = ({1'b0, x2n_reg, 1'b0} <= {2'b00, r2_reg});
                if (sq_stat.done)
                begin
                    row_next   = sq_root;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            armed_reg     <= 1'b0;
            drawing_reg   <= 1'b0;
            centre_x_reg  <= '0;
            centre_y_reg  <= '0;
            column_reg    <= '0;
            row_reg       <= '0;
            octant_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            drawing_reg   <= drawing_next;
            centre_x_reg  <= centre_x_next;
            centre_y_reg  <= centre_y_next;
            column_reg    <= column_next;
            row_reg       <= row_next;
            octant_reg    <= octant_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        dy_reg         <= dy_next;
        x2_reg         <= x2_next;
        x2n_reg        <= x2n_next;
        r2_reg         <= r2_next;
        ok_reg         <= ok_next;
        mcd_reg        <= mcd_next;
        mlr_reg        <= mlr_next;
        acc_reg        <= acc_next;
        out_pvalid_reg <= out_pvalid_next;
        out_px_reg     <= out_px_next;
        out_py_reg     <= out_py_next;
        out_last_reg   <= out_last_next;
        out_busy_reg   <= out_busy_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_pvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_BITS - 2*PIX_BITS - 1){1'b0}},
                       out_busy_reg, out_py_reg, out_px_reg};

endmodule

`default_nettype wire
